// ----- rtl/pss_pkg.sv -----
// Shared types and constants for the plastic surface shader.
// No dependencies; imported by plastic_surface_shade.
package pss_pkg;

  localparam int VB        = 16;   // vector component width
  localparam int CB        = 16;   // color width
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMBIENT  = 3'd0,
    REG_DIFFUSE  = 3'd1,
    REG_SPECULAR = 3'd2,
    REG_ROUGH    = 3'd3,
    REG_LIGHT_R  = 3'd4,
    REG_LIGHT_G  = 3'd5,
    REG_LIGHT_B  = 3'd6
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] AMBIENT_RST  = 16'd6554;
  localparam logic [CFG_W-1:0] DIFFUSE_RST  = 16'd16384;
  localparam logic [CFG_W-1:0] SPECULAR_RST = 16'd16384;
  localparam logic [CFG_W-1:0] ROUGH_RST    = 16'd410;
  localparam logic [CFG_W-1:0] LIGHT_RST    = 16'd32768;

  typedef struct packed {
    logic signed [VB-1:0] normal_x;
    logic signed [VB-1:0] normal_y;
    logic signed [VB-1:0] normal_z;
    logic signed [VB-1:0] incident_x;
    logic signed [VB-1:0] incident_y;
    logic signed [VB-1:0] incident_z;
    logic [CB-1:0]        surface_red;
    logic [CB-1:0]        surface_green;
    logic [CB-1:0]        surface_blue;
  } in_beat_t;

  typedef struct packed {
    logic [CB-1:0] color_red;
    logic [CB-1:0] color_green;
    logic [CB-1:0] color_blue;
  } out_beat_t;

  // Q.30 root 2^(-2^-n), built by repeated floor square roots of 0.5
  function automatic logic [29:0] exp_root(input int unsigned n);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] c;
    logic [63:0] best;
    r = 64'd1 << 29;
    for (int unsigned j = 1; j <= n; j++) begin
      x    = r << 30;
      best = '0;
      for (int b = 31; b >= 0; b--) begin
        c = best | (64'd1 << b);
        if (c * c <= x) best = c;
      end
      r = best;
    end
    return r[29:0];
  endfunction

endpackage

// ----- rtl/plastic_surface_shade.sv -----
// Plastic surface shader top level: config registers and the full shading pipeline.
// Depends on pss_pkg.
//
// Takes one shading point per cycle and returns one shaded color per point, in
// order, while the output is not stalled. The rate is one beat per cycle when not
// stalled; the pipeline is built of eight two-bit square
// root stages for |N| and |I|, a radix-2 divider for the cosine, sixteen
// squaring stages for log2, a divider by roughness and sixteen multiply stages
// for exp2. Backpressure stalls only stages that hold data, so bubbles close up.
// Configuration may be written only while the pipeline is empty.
module plastic_surface_shade (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pss_pkg::in_beat_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pss_pkg::out_beat_t          out_data_o,
  input  logic                        cfg_we_i,
  input  logic [pss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pss_pkg::CFG_W-1:0]   cfg_data_i
);
  import pss_pkg::*;

  localparam int W2       = 2 * VB;
  localparam int ST_MAG   = 0;
  localparam int ST_PROD  = 1;
  localparam int ST_SUM   = 2;
  localparam int ST_NUM   = 3;
  localparam int ST_SQ    = 4;
  localparam int SQ_N     = (VB + 1) / 2;
  localparam int ST_DEN   = ST_SQ + SQ_N;
  localparam int DV_STEPS = 17;
  localparam int DV_N     = (DV_STEPS + 1) / 2;
  localparam int ST_DV    = ST_DEN + 1;
  localparam int ST_MSB   = ST_DV + DV_N;
  localparam int ST_LG    = ST_MSB + 1;
  localparam int LG_N     = 16;
  localparam int ST_NL    = ST_LG + LG_N;
  localparam int PD_STEPS = 21;
  localparam int PD_N     = 7;
  localparam int ST_PD    = ST_NL + 1;
  localparam int ST_EX    = ST_PD + PD_N;
  localparam int EX_N     = 16;
  localparam int ST_SH    = ST_EX + EX_N;
  localparam int ST_CH    = ST_SH + 1;
  localparam int ST_OUT   = ST_CH + 1;
  localparam int NS       = ST_OUT + 1;

  typedef struct packed {
    logic [2:0][CB-1:0]   cs;
    logic [2:0][VB-1:0]   nm;
    logic [2:0][VB-1:0]   im;
    logic [2:0]           sn;
    logic [2:0]           si;
    logic [2:0][W2-1:0]   pn;
    logic [2:0][W2-1:0]   pi;
    logic [2:0][W2-1:0]   px;
    logic [W2-1:0]        nn;
    logic [W2-1:0]        ii;
    logic [W2-1:0]        pos;
    logic [W2-1:0]        neg;
    logic [W2-1:0]        num;
    logic [W2-1:0]        den;
    logic [W2+1:0]        rem_n;
    logic [W2+1:0]        rem_i;
    logic [VB-1:0]        rt_n;
    logic [VB-1:0]        rt_i;
    logic [W2:0]          dr;
    logic [DV_STEPS-1:0]  dq;
    logic                 dzero;
    logic                 dnz;
    logic [4:0]           msb;
    logic [30:0]          m;
    logic [15:0]          lg;
    logic [32:0]          kdd;
    logic [20:0]          nl;
    logic [15:0]          pr;
    logic [PD_STEPS-1:0]  pq;
    logic                 pover;
    logic [30:0]          t;
    logic [16:0]          spec;
    logic [2:0][CB+2:0]   diff;
    logic [2:0][CB+1:0]   sp;
    logic [2:0][CB-1:0]   col;
  } pipe_t;

  logic [CFG_W-1:0] ambient_q, diffuse_q, specular_q, rough_q;
  logic [2:0][CFG_W-1:0] light_q;
  logic [2:0][31:0] lks_q;
  logic [15:0] rough_eff;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;
  pipe_t p_q [NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ambient_q  <= AMBIENT_RST;
      diffuse_q  <= DIFFUSE_RST;
      specular_q <= SPECULAR_RST;
      rough_q    <= ROUGH_RST;
      light_q    <= {3{LIGHT_RST}};
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_AMBIENT:  ambient_q  <= cfg_data_i;
        REG_DIFFUSE:  diffuse_q  <= cfg_data_i;
        REG_SPECULAR: specular_q <= cfg_data_i;
        REG_ROUGH:    rough_q    <= cfg_data_i;
        REG_LIGHT_R:  light_q[0] <= cfg_data_i;
        REG_LIGHT_G:  light_q[1] <= cfg_data_i;
        REG_LIGHT_B:  light_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // light * Ks, refreshed every cycle from the registers
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      lks_q[c] <= 32'(light_q[c]) * 32'(specular_q);
    end
  end

  assign rough_eff = (rough_q == '0) ? 16'd1 : rough_q;

  // stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign out_data_o.color_red   = p_q[NS-1].col[0];
  assign out_data_o.color_green = p_q[NS-1].col[1];
  assign out_data_o.color_blue  = p_q[NS-1].col[2];

  for (genvar k = 0; k < NS; k++) begin : g_st
    pipe_t nx;

    if (k == ST_MAG) begin : g_mag
      always_comb begin
        logic [2:0][VB-1:0] nv;
        logic [2:0][VB-1:0] iv;
        nv = {in_data_i.normal_z, in_data_i.normal_y, in_data_i.normal_x};
        iv = {in_data_i.incident_z, in_data_i.incident_y, in_data_i.incident_x};
        nx = '0;
        for (int c = 0; c < 3; c++) begin
          nx.sn[c] = nv[c][VB-1];
          nx.si[c] = iv[c][VB-1];
          nx.nm[c] = nv[c][VB-1] ? (~nv[c] + 1'b1) : nv[c];
          nx.im[c] = iv[c][VB-1] ? (~iv[c] + 1'b1) : iv[c];
        end
        nx.cs = {in_data_i.surface_blue, in_data_i.surface_green, in_data_i.surface_red};
      end
    end else if (k == ST_PROD) begin : g_prod
      always_comb begin
        nx = p_q[k-1];
        for (int c = 0; c < 3; c++) begin
          nx.pn[c] = W2'(p_q[k-1].nm[c]) * W2'(p_q[k-1].nm[c]);
          nx.pi[c] = W2'(p_q[k-1].im[c]) * W2'(p_q[k-1].im[c]);
          nx.px[c] = W2'(p_q[k-1].nm[c]) * W2'(p_q[k-1].im[c]);
        end
      end
    end else if (k == ST_SUM) begin : g_sum
      always_comb begin
        nx     = p_q[k-1];
        nx.nn  = p_q[k-1].pn[0] + p_q[k-1].pn[1] + p_q[k-1].pn[2];
        nx.ii  = p_q[k-1].pi[0] + p_q[k-1].pi[1] + p_q[k-1].pi[2];
        nx.pos = '0;
        nx.neg = '0;
        for (int c = 0; c < 3; c++) begin
          if (p_q[k-1].sn[c] == p_q[k-1].si[c]) nx.pos = nx.pos + p_q[k-1].px[c];
          else nx.neg = nx.neg + p_q[k-1].px[c];
        end
      end
    end else if (k == ST_NUM) begin : g_num
      always_comb begin
        nx       = p_q[k-1];
        nx.num   = (p_q[k-1].pos >= p_q[k-1].neg) ? p_q[k-1].pos - p_q[k-1].neg
                                                  : p_q[k-1].neg - p_q[k-1].pos;
        nx.rem_n = (W2+2)'(p_q[k-1].nn);
        nx.rem_i = (W2+2)'(p_q[k-1].ii);
        nx.rt_n  = '0;
        nx.rt_i  = '0;
      end
    end else if (k >= ST_SQ && k < ST_SQ + SQ_N) begin : g_sqrt
      localparam int S = k - ST_SQ;
      always_comb begin
        logic [W2+1:0] tn;
        logic [W2+1:0] ti;
        int b;
        nx = p_q[k-1];
        for (int j = 0; j < 2; j++) begin
          b = VB - 1 - 2 * S - j;
          if (b >= 0) begin
            tn = ((W2+2)'(nx.rt_n) << (b + 1)) + ((W2+2)'(1) << (2 * b));
            ti = ((W2+2)'(nx.rt_i) << (b + 1)) + ((W2+2)'(1) << (2 * b));
            if (nx.rem_n >= tn) begin
              nx.rem_n = nx.rem_n - tn;
              nx.rt_n  = nx.rt_n | (VB'(1) << b);
            end
            if (nx.rem_i >= ti) begin
              nx.rem_i = nx.rem_i - ti;
              nx.rt_i  = nx.rt_i | (VB'(1) << b);
            end
          end
        end
      end
    end else if (k == ST_DEN) begin : g_den
      always_comb begin
        logic [W2-1:0] dv;
        dv       = W2'(p_q[k-1].rt_n) * W2'(p_q[k-1].rt_i);
        nx       = p_q[k-1];
        nx.den   = dv;
        nx.dzero = (dv == '0);
        nx.dr    = (p_q[k-1].num > dv) ? {1'b0, dv} : {1'b0, p_q[k-1].num};
        nx.dq    = '0;
      end
    end else if (k >= ST_DV && k < ST_DV + DV_N) begin : g_div
      localparam int S = k - ST_DV;
      always_comb begin
        int st;
        nx = p_q[k-1];
        for (int j = 0; j < 2; j++) begin
          st = 2 * S + j;
          if (st < DV_STEPS) begin
            if (st != 0) nx.dr = {nx.dr[W2-1:0], 1'b0};
            if (nx.dr >= {1'b0, nx.den}) begin
              nx.dr = nx.dr - {1'b0, nx.den};
              nx.dq[DV_STEPS-1-st] = 1'b1;
            end
          end
        end
      end
    end else if (k == ST_MSB) begin : g_msb
      always_comb begin
        logic [16:0] d;
        logic [46:0] sh;
        d  = p_q[k-1].dzero ? 17'd0 : p_q[k-1].dq;
        nx = p_q[k-1];
        nx.msb = '0;
        for (int i = 0; i < 17; i++) begin
          if (d[i]) nx.msb = 5'(i);
        end
        sh     = 47'(d) << (5'd30 - nx.msb);
        nx.m   = sh[30:0];
        nx.lg  = '0;
        nx.dnz = (d != '0);
        nx.kdd = 33'(diffuse_q) * 33'(d);
      end
    end else if (k >= ST_LG && k < ST_LG + LG_N) begin : g_log
      always_comb begin
        logic [61:0] sq;
        sq = 62'(p_q[k-1].m) * 62'(p_q[k-1].m);
        nx = p_q[k-1];
        nx.lg = {p_q[k-1].lg[14:0], sq[61]};
        nx.m  = sq[61] ? sq[61:31] : sq[60:30];
      end
    end else if (k == ST_NL) begin : g_nl
      always_comb begin
        logic [20:0] nlv;
        nlv      = (21'd16 << 16) - {p_q[k-1].msb, p_q[k-1].lg};
        nx       = p_q[k-1];
        nx.nl    = nlv;
        nx.pover = 16'(nlv[20:6]) >= rough_eff;
        nx.pr    = 16'(nlv[20:6]);
        nx.pq    = '0;
        nx.t     = 31'(1) << 30;
      end
    end else if (k >= ST_PD && k < ST_PD + PD_N) begin : g_pdiv
      localparam int S = k - ST_PD;
      always_comb begin
        logic [35:0] ext;
        logic [16:0] r;
        int i;
        nx  = p_q[k-1];
        ext = {p_q[k-1].nl, 15'd0};
        for (int j = 0; j < 3; j++) begin
          i = PD_STEPS - 1 - (3 * S + j);
          if (i >= 0) begin
            r = {nx.pr, ext[i]};
            if (r >= {1'b0, rough_eff}) begin
              r = r - {1'b0, rough_eff};
              nx.pq[i] = 1'b1;
            end
            nx.pr = r[15:0];
          end
        end
      end
    end else if (k >= ST_EX && k < ST_EX + EX_N) begin : g_exp
      localparam int S = k - ST_EX;
      localparam logic [29:0] ROOT = exp_root(S + 1);
      always_comb begin
        logic [60:0] prod;
        prod = 61'(p_q[k-1].t) * 61'(ROOT);
        nx = p_q[k-1];
        if (p_q[k-1].pq[15-S]) nx.t = prod[60:30];
      end
    end else if (k == ST_SH) begin : g_shift
      always_comb begin
        logic [4:0] ip;
        ip = p_q[k-1].pq[20:16];
        nx = p_q[k-1];
        if (!p_q[k-1].dnz || p_q[k-1].pover || ip >= 5'd17) nx.spec = '0;
        else nx.spec = 17'(p_q[k-1].t >> (6'(ip) + 6'd14));
      end
    end else if (k == ST_CH) begin : g_chan
      always_comb begin
        logic [33:0] g;
        logic [CB+33:0] dp;
        logic [48:0] spp;
        g  = (34'(ambient_q) << 16) + 34'(p_q[k-1].kdd);
        nx = p_q[k-1];
        for (int c = 0; c < 3; c++) begin
          dp  = (CB+34)'(p_q[k-1].cs[c]) * (CB+34)'(g);
          spp = 49'(lks_q[c]) * 49'(p_q[k-1].spec);
          nx.diff[c] = dp[CB+33:31];
          nx.sp[c]   = spp[48:47-CB];
        end
      end
    end else begin : g_out
      always_comb begin
        logic [CB+3:0] sum;
        nx = p_q[k-1];
        for (int c = 0; c < 3; c++) begin
          sum = (CB+4)'(p_q[k-1].diff[c]) + (CB+4)'(p_q[k-1].sp[c]);
          nx.col[c] = (sum[CB+3:CB] != '0) ? {CB{1'b1}} : sum[CB-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) p_q[k] <= nx;
    end
  end

endmodule

// ----- tb/sv/tb_plastic_surface_shade.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for plastic_surface_shade: streams shading points,
// predicts each shaded color in-house and compares every output beat.
// Depends on pss_pkg and the plastic_surface_shade RTL.
module tb_plastic_surface_shade;
  import pss_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 90;
  localparam int HOLD_CYCLES = 600;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_beat_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  plastic_surface_shade dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shader settings as the predictor sees them
  bit [63:0] ka, kd, ks, rough_q12, lt_r, lt_g, lt_b;
  bit [63:0] exp_roots [1:16];

  out_beat_t expected_colors [$];
  int unsigned mismatches = 0;
  int unsigned send_idle = 0, recv_idle = 0;
  int unsigned hold_left = 0;
  bit hold_req = 1'b0;
  longint unsigned cycles = 0;

  function automatic bit [63:0] floor_sqrt(bit [63:0] x);
    bit [63:0] r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic bit [63:0] cosine_q16(in_beat_t p);
    longint nn, ii, dot;
    bit [63:0] num, den;
    longint n [3], v [3];
    n = '{p.normal_x, p.normal_y, p.normal_z};
    v = '{p.incident_x, p.incident_y, p.incident_z};
    nn = 0; ii = 0; dot = 0;
    for (int k = 0; k < 3; k++) begin
      nn += n[k] * n[k];
      ii += v[k] * v[k];
      dot += n[k] * v[k];
    end
    num = dot < 0 ? -dot : dot;
    den = floor_sqrt(nn) * floor_sqrt(ii);
    if (den == 0) return 0;
    if (num > den) num = den;
    while (den >= (64'd1 << 47)) begin
      num >>= 1;
      den >>= 1;
    end
    return (num << 16) / den;
  endfunction

  function automatic bit [63:0] highlight_q16(bit [63:0] d);
    bit [63:0] rgh, m, lg, p, f, t;
    int msb, ip;
    rgh = rough_q12 == 0 ? 1 : rough_q12;
    if (d == 0) return 0;
    msb = 0;
    while ((d >> (msb + 1)) != 0) msb++;
    m = d << (30 - msb);
    lg = 0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      lg <<= 1;
      if (m >= (64'd1 << 31)) begin
        lg |= 1;
        m >>= 1;
      end
    end
    lg |= 64'(msb) << 16;
    p = (((64'd16 << 16) - lg) << 15) / rgh;
    ip = int'(p >> 16);
    if (ip >= 17) return 0;
    f = p & 64'hFFFF;
    t = 64'd1 << 30;
    for (int i = 1; i <= 16; i++)
      if ((f >> (16 - i)) & 1) t = (t * exp_roots[i]) >> 30;
    return t >> (14 + ip);
  endfunction

  function automatic logic [CB-1:0] lit_channel(bit [63:0] cs, bit [63:0] lt,
                                                bit [63:0] d, bit [63:0] hl);
    bit [63:0] sum;
    sum = ((cs * ((ka << 16) + kd * d)) >> 31) + ((lt * ks * hl) >> (47 - CB));
    return sum > 64'hFFFF ? 16'hFFFF : sum[CB-1:0];
  endfunction

  function automatic out_beat_t shade_point(in_beat_t p);
    out_beat_t o;
    bit [63:0] d, hl;
    d = cosine_q16(p);
    hl = highlight_q16(d);
    o.color_red = lit_channel(p.surface_red, lt_r, d, hl);
    o.color_green = lit_channel(p.surface_green, lt_g, d, hl);
    o.color_blue = lit_channel(p.surface_blue, lt_b, d, hl);
    return o;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    out_ready_i <= (hold_left <= 1) && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_data_o);
      end else begin
        want = expected_colors.pop_front();
        if (want.color_red !== out_data_o.color_red ||
            want.color_green !== out_data_o.color_green ||
            want.color_blue !== out_data_o.color_blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("color mismatch: exp r%0d g%0d b%0d got r%0d g%0d b%0d",
                     want.color_red, want.color_green, want.color_blue,
                     out_data_o.color_red, out_data_o.color_green,
                     out_data_o.color_blue);
        end
      end
    end
  end

  task automatic send_point(in_beat_t p);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    expected_colors.push_back(shade_point(p));
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_AMBIENT:  ka = val;
      REG_DIFFUSE:  kd = val;
      REG_SPECULAR: ks = val;
      REG_ROUGH:    rough_q12 = val;
      REG_LIGHT_R:  lt_r = val;
      REG_LIGHT_G:  lt_g = val;
      REG_LIGHT_B:  lt_b = val;
      default: ;
    endcase
  endtask

  task automatic set_shader(logic [15:0] a, logic [15:0] d, logic [15:0] s,
                            logic [15:0] r, logic [15:0] lr, logic [15:0] lg,
                            logic [15:0] lb);
    write_reg(REG_AMBIENT, a);
    write_reg(REG_DIFFUSE, d);
    write_reg(REG_SPECULAR, s);
    write_reg(REG_ROUGH, r);
    write_reg(REG_LIGHT_R, lr);
    write_reg(REG_LIGHT_G, lg);
    write_reg(REG_LIGHT_B, lb);
  endtask

  function automatic logic [15:0] rand_comp(int unsigned style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(64)) - 32);
      2: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  function automatic in_beat_t rand_point();
    in_beat_t p;
    int unsigned st, kind, sc;
    st = $urandom_range(3);
    p.normal_x = rand_comp(st);
    p.normal_y = rand_comp(st);
    p.normal_z = rand_comp(st);
    kind = $urandom_range(9);
    sc = $urandom_range(1, 3);
    if (kind < 3) begin
      // incident a scaled copy of the normal, x sign sometimes flipped, aiming at a strong highlight
      p.incident_x = 16'(p.normal_x / 4 * int'(sc) * ($urandom_range(1) ? 1 : -1));
      p.incident_y = 16'(p.normal_y / 4 * int'(sc));
      p.incident_z = 16'(p.normal_z / 4 * int'(sc));
      if ($urandom_range(1))
        p.incident_y = p.incident_y + 16'($urandom_range(6)) - 16'd3;
    end else begin
      p.incident_x = rand_comp($urandom_range(3));
      p.incident_y = rand_comp($urandom_range(3));
      p.incident_z = rand_comp($urandom_range(3));
    end
    if (kind == 9) p.normal_x = '0;
    if (kind == 9 && $urandom_range(1)) {p.normal_y, p.normal_z} = '0;
    p.surface_red = $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom);
    p.surface_green = 16'($urandom);
    p.surface_blue = $urandom_range(7) == 0 ? 16'h0 : 16'($urandom);
    return p;
  endfunction

  function automatic in_beat_t make_point(logic [15:0] nx, logic [15:0] ny,
                                          logic [15:0] nz, logic [15:0] ix,
                                          logic [15:0] iy, logic [15:0] iz,
                                          logic [15:0] c);
    in_beat_t p;
    p = '{nx, ny, nz, ix, iy, iz, c, ~c, 16'h8000};
    return p;
  endfunction

  task automatic test_directed;
    send_point(make_point(0, 0, 0, 100, 200, 300, 16'hFFFF));
    send_point(make_point(5, 6, 7, 0, 0, 0, 16'h8000));
    send_point(make_point(0, 0, 0, 0, 0, 0, 16'h0));
    send_point(make_point(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000, 16'hFFFF));
    send_point(make_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                          16'h8000, 16'h1234));
    send_point(make_point(0, 0, 1, 0, 0, 1, 16'h8000));
    send_point(make_point(0, 0, 1, 0, 0, 16'hFFFF, 16'h8000));
    send_point(make_point(1, 0, 0, 0, 1, 0, 16'h8000));
    send_point(make_point(100, 0, 1, 0, 100, 0, 16'hFFFF));
    send_point(make_point(3, 4, 0, 6, 8, 0, 16'h7FFF));
    send_point(make_point(1, 1, 1, 1, 1, 0, 16'hAAAA));
    send_point(make_point(16'h5555, 16'hAAAA, 16'h0001, 16'hAAAA, 16'h5555,
                          16'hFFFE, 16'h5555));
  endtask

  task automatic test_random(int unsigned count);
    repeat (count) send_point(rand_point());
  endtask

  task automatic test_backpressure;
    in_valid_i <= 1'b0;
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    repeat (150) send_point(rand_point());
    drain();
  endtask

  task automatic test_settings;
    set_shader(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_directed(); test_random(40); drain();
    set_shader(0, 0, 0, 16'hFFFF, 0, 0, 0);
    test_directed(); test_random(40); drain();
    set_shader(0, 16'h8000, 16'h8000, 16'd0, 16'h8000, 16'h4000, 16'hFFFF);
    write_reg(cfg_reg_e'(3'd7), 16'hFFFF);
    test_directed(); test_random(40); drain();
    set_shader(16'd6554, 16'd30000, 16'd20000, 16'd4096, 16'd40000, 16'd32768,
               16'd100);
    test_random(60); drain();
  endtask

  initial begin
    ka = AMBIENT_RST; kd = DIFFUSE_RST; ks = SPECULAR_RST; rough_q12 = ROUGH_RST;
    lt_r = LIGHT_RST; lt_g = LIGHT_RST; lt_b = LIGHT_RST;
    exp_roots[1] = floor_sqrt(64'd1 << 59);
    for (int i = 2; i <= 16; i++) exp_roots[i] = floor_sqrt(exp_roots[i-1] << 30);
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 30; recv_idle = 83;
    test_directed();
    test_random(500);
    drain();
    test_settings();
    send_idle = 83; recv_idle = 30;
    test_random(500);
    test_backpressure();
    send_idle = 0; recv_idle = 0;
    test_random(500);
    drain();

    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
